@@ hdl/bht_pkg.sv @@
// shared types and codes for the bucketed hash table unit
package bht_pkg;

   localparam int KEY_W = 64;
   localparam int VAL_W = 64;

   localparam logic [1:0] OP_GET = 2'd0;
   localparam logic [1:0] OP_PUT = 2'd1;
   localparam logic [1:0] OP_REM = 2'd2;
   localparam logic [1:0] OP_BAD = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_ZERO = 2'd3;

   typedef enum logic [2:0] {
      CLS_GET,
      CLS_PUT,
      CLS_REM,
      CLS_BAD,
      CLS_ZERO
   } cls_type;

   typedef struct packed {
      cls_type            cls;
      logic [KEY_W-1:0]   key;
      logic [VAL_W-1:0]   value;
   } item_type;

endpackage

@@ hdl/bucketed_hash_table_unit.sv @@
// top level of the bucketed hash table unit
// a request passes the front end states F_IDLE, F_MUL and F_PUSH, then the engine reads and checks
//   the home bucket (E_RD, E_CHK) and each chained bucket walked; a rejected op or key zero skips the walk
// the front end takes no new request until the last one is pushed, and the engine handles one item
//   at a time through the single bucket-wide read port of the memories; a stalled response holds it
// reset: a clearing pass over all HOME_BUCKETS+OVERFLOW_BUCKETS buckets empties all slots
//   and links; req_stall stays high until it ends; bucket_count_log2 resets to 10
module bucketed_hash_table_unit
   import bht_pkg::*;
#(
   parameter int HOME_BUCKETS = 1024,
   parameter int SLOTS_PER_BUCKET = 3,
   parameter int OVERFLOW_BUCKETS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_op,
   input  logic [KEY_W-1:0]  req_key,
   input  logic [VAL_W-1:0]  req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [VAL_W-1:0]  rsp_result_value,
   output logic [1:0]        rsp_status,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_bucket_count_log2
);

   localparam int BW = $clog2(HOME_BUCKETS + OVERFLOW_BUCKETS);
   localparam int QW = $bits(item_type) + BW;

   logic           clearing;
   logic           push;
   logic           q_full;
   item_type       push_item;
   logic [BW-1:0]  push_home;
   logic           pop;
   logic           q_empty;
   logic [QW-1:0]  pop_data;
   item_type       q_item;
   logic [BW-1:0]  q_home;

   assign q_item = pop_data[QW-1:BW];
   assign q_home = pop_data[BW-1:0];

   bht_front #(
      .HOME_BUCKETS (HOME_BUCKETS),
      .BW           (BW)
   ) u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_op                (req_op),
      .req_key               (req_key),
      .req_value             (req_value),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_bucket_count_log2 (csr_bucket_count_log2),
      .clearing              (clearing),
      .push                  (push),
      .q_full                (q_full),
      .push_item             (push_item),
      .push_home             (push_home)
   );

   bht_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_item, push_home}),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   bht_engine #(
      .HOME_BUCKETS     (HOME_BUCKETS),
      .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
      .OVERFLOW_BUCKETS (OVERFLOW_BUCKETS),
      .BW               (BW)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_item           (q_item),
      .q_home           (q_home),
      .pop              (pop),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

endmodule

@@ hdl/bht_front.sv @@
// front end: takes request beats, classifies them and computes the home bucket
module bht_front
   import bht_pkg::*;
#(
   parameter int HOME_BUCKETS = 1024,
   parameter int BW = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_op,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [VAL_W-1:0]    req_value,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [3:0]          csr_bucket_count_log2,
   input  logic                clearing,
   output logic                push,
   input  logic                q_full,
   output item_type            push_item,
   output logic [BW-1:0]       push_home
);

   localparam logic [32:0] RECIP = 33'((64'd1 << 32) / HOME_BUCKETS);
   localparam logic [16:0] HB    = 17'(HOME_BUCKETS);

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_type;

   fstate_type        state_ff;
   logic [3:0]        lg_ff;
   logic [1:0]        op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [VAL_W-1:0]  value_ff;
   logic [15:0]       x_ff;
   logic [48:0]       prod_ff;
   logic [15:0]       mask_in;
   logic [16:0]       quot;
   logic [33:0]       rem_a;
   logic [33:0]       rem_b;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != F_IDLE) || clearing;
   assign mask_in   = ~(16'hffff << lg_ff);

   // reciprocal estimate is low by at most one, so one correction step
   assign quot  = prod_ff[48:32];
   assign rem_a = 34'(x_ff) - (34'(quot) * 34'(HB));
   assign rem_b = (rem_a >= 34'(HB)) ? (rem_a - 34'(HB)) : rem_a;

   always_comb begin
      push_item.key   = key_ff;
      push_item.value = value_ff;
      push_home       = BW'(rem_b);
      if (op_ff == OP_BAD) begin
         push_item.cls = CLS_BAD;
      end else if (key_ff == '0) begin
         push_item.cls = CLS_ZERO;
      end else if (op_ff == OP_PUT) begin
         push_item.cls = CLS_PUT;
      end else if (op_ff == OP_REM) begin
         push_item.cls = CLS_REM;
      end else begin
         push_item.cls = CLS_GET;
      end
   end

   assign push = (state_ff == F_PUSH) && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         lg_ff    <= 4'd10;
      end else begin
         if (csr_valid && csr_ready) begin
            lg_ff <= csr_bucket_count_log2;
         end
         unique case (state_ff)
            F_IDLE: begin
               if (req_valid && !req_stall) begin
                  op_ff    <= req_op;
                  key_ff   <= req_key;
                  value_ff <= req_value;
                  x_ff     <= req_key[15:0] & mask_in;
                  state_ff <= F_MUL;
               end
            end
            F_MUL: begin
               prod_ff  <= 49'(x_ff) * 49'(RECIP);
               state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (!q_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

@@ hdl/bht_queue.sv @@
// two-entry queue between front end and table engine
module bht_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff;
   logic             rd_ff;
   logic [1:0]       cnt_ff;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

@@ hdl/bht_engine.sv @@
// table engine: bucket memories, chain walk, write-back and result register
module bht_engine
   import bht_pkg::*;
#(
   parameter int HOME_BUCKETS = 1024,
   parameter int SLOTS_PER_BUCKET = 3,
   parameter int OVERFLOW_BUCKETS = 256,
   parameter int BW = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  item_type          q_item,
   input  logic [BW-1:0]     q_home,
   output logic              pop,
   output logic              clearing,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [VAL_W-1:0]  rsp_result_value,
   output logic [1:0]        rsp_status
);

   localparam int TOTAL = HOME_BUCKETS + OVERFLOW_BUCKETS;
   localparam int S     = SLOTS_PER_BUCKET;
   localparam int SW    = (S > 1) ? $clog2(S) : 1;
   localparam int LW    = $clog2(OVERFLOW_BUCKETS + 1);
   localparam int HW    = $clog2(OVERFLOW_BUCKETS + 1) + 1;

   typedef enum logic [1:0] {E_CLEAR, E_IDLE, E_RD, E_CHK} estate_type;

   logic [KEY_W-1:0] keys_mem  [TOTAL][S];
   logic [VAL_W-1:0] vals_mem  [TOTAL][S];
   logic [LW-1:0]    links_mem [TOTAL];

   estate_type       state_ff;
   logic [BW-1:0]    clr_ff;
   logic [BW-1:0]    cur_ff;
   logic [HW-1:0]    hops_ff;
   logic [LW-1:0]    ou_ff;
   item_type         item_ff;
   logic             emp_valid_ff;
   logic [BW-1:0]    emp_bkt_ff;
   logic [SW-1:0]    emp_slot_ff;
   logic [KEY_W-1:0] key_row_ff [S];
   logic [VAL_W-1:0] val_row_ff [S];
   logic [LW-1:0]    link_ff;
   logic             rsp_valid_ff;
   logic [VAL_W-1:0] res_ff;
   logic [1:0]       st_ff;

   logic             out_free;
   logic             match;
   logic [SW-1:0]    match_j;
   logic             empty_here;
   logic [SW-1:0]    empty_j;
   logic             can_go;
   logic [BW-1:0]    nxt_bkt;
   logic             fin;
   logic [VAL_W-1:0] fin_res;
   logic [1:0]       fin_st;
   logic             kw_en;
   logic [BW-1:0]    kw_bkt;
   logic [SW-1:0]    kw_slot;
   logic [KEY_W-1:0] kw_data;
   logic             vw_en;
   logic             lw_en;
   logic             grow;
   logic             rsp_load;

   assign clearing         = (state_ff == E_CLEAR);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = res_ff;
   assign rsp_status       = st_ff;
   assign out_free         = !rsp_valid_ff || !rsp_stall;
   assign pop              = (state_ff == E_IDLE) && !q_empty && out_free;
   assign rsp_load         = (pop && (q_item.cls == CLS_BAD || q_item.cls == CLS_ZERO))
                             || fin;

   always_comb begin
      match      = 1'b0;
      match_j    = '0;
      empty_here = 1'b0;
      empty_j    = '0;
      for (int j = S - 1; j >= 0; j--) begin
         if (key_row_ff[j] == item_ff.key) begin
            match   = 1'b1;
            match_j = SW'(j);
         end
         if (key_row_ff[j] == '0) begin
            empty_here = 1'b1;
            empty_j    = SW'(j);
         end
      end
   end

   assign nxt_bkt = BW'(HOME_BUCKETS) + BW'(link_ff) - BW'(1);
   assign can_go  = (link_ff != '0) && ((link_ff - LW'(1)) < LW'(OVERFLOW_BUCKETS))
                    && (hops_ff < HW'(OVERFLOW_BUCKETS));

   // decisions at the end of one bucket inspection
   always_comb begin
      fin     = 1'b0;
      fin_res = '0;
      fin_st  = ST_OK;
      kw_en   = 1'b0;
      kw_bkt  = cur_ff;
      kw_slot = match_j;
      kw_data = '0;
      vw_en   = 1'b0;
      lw_en   = 1'b0;
      grow    = 1'b0;
      if (state_ff == E_CHK) begin
         if (item_ff.cls == CLS_PUT) begin
            if (match) begin
               fin    = 1'b1;
               fin_st = ST_MISS;
            end else if (!can_go) begin
               fin = 1'b1;
               if (emp_valid_ff || empty_here) begin
                  kw_en   = 1'b1;
                  vw_en   = 1'b1;
                  kw_data = item_ff.key;
                  kw_bkt  = emp_valid_ff ? emp_bkt_ff : cur_ff;
                  kw_slot = emp_valid_ff ? emp_slot_ff : empty_j;
               end else if (ou_ff >= LW'(OVERFLOW_BUCKETS)) begin
                  fin_st = ST_FULL;
               end else begin
                  // link a fresh overflow bucket at the chain tail
                  grow    = 1'b1;
                  lw_en   = 1'b1;
                  kw_en   = 1'b1;
                  vw_en   = 1'b1;
                  kw_data = item_ff.key;
                  kw_bkt  = BW'(HOME_BUCKETS) + BW'(ou_ff);
                  kw_slot = '0;
               end
            end
         end else begin
            if (match) begin
               fin     = 1'b1;
               fin_res = val_row_ff[match_j];
               kw_en   = (item_ff.cls == CLS_REM);
            end else if (!can_go) begin
               fin    = 1'b1;
               fin_st = ST_MISS;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == E_CLEAR) begin
         for (int j = 0; j < S; j++) begin
            keys_mem[clr_ff][j] <= '0;
         end
         links_mem[clr_ff] <= '0;
      end else begin
         if (kw_en) begin
            keys_mem[kw_bkt][kw_slot] <= kw_data;
         end
         if (vw_en) begin
            vals_mem[kw_bkt][kw_slot] <= item_ff.value;
         end
         if (lw_en) begin
            links_mem[cur_ff] <= ou_ff + LW'(1);
         end
      end
      key_row_ff <= keys_mem[cur_ff];
      val_row_ff <= vals_mem[cur_ff];
      link_ff    <= links_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= E_CLEAR;
         clr_ff       <= '0;
         ou_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            E_CLEAR: begin
               clr_ff <= clr_ff + BW'(1);
               if (clr_ff == BW'(TOTAL - 1)) begin
                  state_ff <= E_IDLE;
               end
            end
            E_IDLE: begin
               if (pop) begin
                  item_ff      <= q_item;
                  cur_ff       <= q_home;
                  hops_ff      <= '0;
                  emp_valid_ff <= 1'b0;
                  if (q_item.cls == CLS_BAD || q_item.cls == CLS_ZERO) begin
                     res_ff <= '0;
                     st_ff  <= (q_item.cls == CLS_BAD) ? ST_MISS : ST_ZERO;
                  end else begin
                     state_ff <= E_RD;
                  end
               end
            end
            E_RD: begin
               state_ff <= E_CHK;
            end
            E_CHK: begin
               if (fin) begin
                  res_ff   <= fin_res;
                  st_ff    <= fin_st;
                  state_ff <= E_IDLE;
                  if (grow) begin
                     ou_ff <= ou_ff + LW'(1);
                  end
               end else begin
                  if (!emp_valid_ff && empty_here) begin
                     emp_valid_ff <= 1'b1;
                     emp_bkt_ff   <= cur_ff;
                     emp_slot_ff  <= empty_j;
                  end
                  cur_ff   <= nxt_bkt;
                  hops_ff  <= hops_ff + HW'(1);
                  state_ff <= E_RD;
               end
            end
            default: state_ff <= E_IDLE;
         endcase
      end
   end

endmodule

@@ dv/bucketed_hash_table_unit_tb.sv @@
// testbench for the bucketed hash table unit: directed table plus random traffic, scoreboarded
`timescale 1ns / 1ps

module bucketed_hash_table_unit_tb;
   import bht_pkg::*;

   localparam int HOME_BUCKETS = 1024;
   localparam int SLOTS_PER_BUCKET = 3;
   localparam int OVERFLOW_BUCKETS = 256;
   localparam int TOTAL_BUCKETS = HOME_BUCKETS + OVERFLOW_BUCKETS;
   localparam int TOTAL_SLOTS = TOTAL_BUCKETS * SLOTS_PER_BUCKET;
   localparam int NUM_RANDOM = 380;

   typedef struct {
      logic [VAL_W-1:0] value;
      logic [1:0]       status;
   } outcome_type;

   typedef struct {
      logic [1:0]       op;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      bit               typed;
      logic [VAL_W-1:0] exp_value;
      logic [1:0]       exp_status;
   } row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [1:0]       req_op;
   logic [KEY_W-1:0] req_key;
   logic [VAL_W-1:0] req_value;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [VAL_W-1:0] rsp_result_value;
   logic [1:0]       rsp_status;
   logic             csr_valid;
   logic             csr_ready;
   logic [3:0]       csr_bucket_count_log2;

   bucketed_hash_table_unit #(
      .HOME_BUCKETS(HOME_BUCKETS),
      .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET),
      .OVERFLOW_BUCKETS(OVERFLOW_BUCKETS)
   ) dut (.*);

   // table mirror
   logic [KEY_W-1:0] tbl_keys[TOTAL_SLOTS];
   logic [VAL_W-1:0] tbl_values[TOTAL_SLOTS];
   int               tbl_links[TOTAL_BUCKETS];
   int               pool_used;
   logic [3:0]       mask_bits;

   outcome_type      pending_rsp[$];
   logic [KEY_W-1:0] live_keys[$];
   int               mismatches;
   int               rsp_count;
   bit               stim_done;
   bit               hold_rsp;
   bit               quiet;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int home_bucket(logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] m;
      m = (64'd1 << mask_bits) - 64'd1;
      return int'((k & m) % HOME_BUCKETS);
   endfunction

   function automatic int next_bucket(int b);
      if (tbl_links[b] == 0 || tbl_links[b] - 1 >= OVERFLOW_BUCKETS) return -1;
      return HOME_BUCKETS + tbl_links[b] - 1;
   endfunction

   function automatic int locate_key(logic [KEY_W-1:0] k);
      int b;
      b = home_bucket(k);
      for (int h = 0; h <= OVERFLOW_BUCKETS; h++) begin
         for (int j = 0; j < SLOTS_PER_BUCKET; j++)
            if (tbl_keys[b*SLOTS_PER_BUCKET+j] == k) return b*SLOTS_PER_BUCKET+j;
         if (next_bucket(b) < 0) break;
         b = next_bucket(b);
      end
      return -1;
   endfunction

   function automatic logic [1:0] insert_entry(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      int b;
      int free_slot;
      int s;
      b = home_bucket(k);
      free_slot = -1;
      for (int h = 0; h <= OVERFLOW_BUCKETS; h++) begin
         for (int j = 0; j < SLOTS_PER_BUCKET; j++) begin
            s = b*SLOTS_PER_BUCKET + j;
            if (tbl_keys[s] == k) return ST_MISS;
            if (free_slot < 0 && tbl_keys[s] == '0) free_slot = s;
         end
         if (next_bucket(b) < 0) break;
         b = next_bucket(b);
      end
      if (free_slot >= 0) begin
         tbl_keys[free_slot] = k;
         tbl_values[free_slot] = v;
         return ST_OK;
      end
      if (pool_used >= OVERFLOW_BUCKETS) return ST_FULL;
      s = (HOME_BUCKETS + pool_used) * SLOTS_PER_BUCKET;
      tbl_links[b] = pool_used + 1;
      pool_used++;
      tbl_keys[s] = k;
      tbl_values[s] = v;
      return ST_OK;
   endfunction

   function automatic outcome_type apply_op(logic [1:0] op, logic [KEY_W-1:0] k,
                                            logic [VAL_W-1:0] v);
      outcome_type o;
      int s;
      o.value = '0;
      if (op == OP_BAD) o.status = ST_MISS;
      else if (k == '0) o.status = ST_ZERO;
      else if (op == OP_PUT) begin
         o.status = insert_entry(k, v);
         if (o.status == ST_OK) live_keys.push_back(k);
      end else begin
         s = locate_key(k);
         if (s < 0) o.status = ST_MISS;
         else begin
            o.value = tbl_values[s];
            o.status = ST_OK;
            if (op == OP_REM) tbl_keys[s] = '0;
         end
      end
      return o;
   endfunction

   task automatic idle_maybe();
      if (!quiet && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   // valid stays high into the next beat; idle gaps and pauses drop it
   task automatic send_item(row_type r);
      outcome_type o;
      idle_maybe();
      req_valid <= 1'b1;
      req_op <= r.op;
      req_key <= r.key;
      req_value <= r.value;
      do @(posedge clock); while (req_stall);
      o = apply_op(r.op, r.key, r.value);
      if (r.typed && (o.value !== r.exp_value || o.status !== r.exp_status)) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row key %h: exp value %h status %0d, mirror value %h status %0d",
                     r.key, r.exp_value, r.exp_status, o.value, o.status);
      end
      if (r.typed) begin
         o.value = r.exp_value;
         o.status = r.exp_status;
      end
      pending_rsp.push_back(o);
      @(negedge clock);
   endtask

   task automatic set_mask(logic [3:0] lg);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_valid <= 1'b1;
      csr_bucket_count_log2 <= lg;
      do @(posedge clock); while (!csr_ready);
      mask_bits = lg;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [KEY_W-1:0] rand_key();
      logic [KEY_W-1:0] k;
      case ($urandom_range(3))
         0: k = {$urandom, $urandom};
         1: k = 64'($urandom_range(1, 40));
         2: k = {$urandom, $urandom} & 64'hF00000000000003F;
         default: k = live_keys.size() ? live_keys[$urandom_range(live_keys.size()-1)]
                                        : 64'd1;
      endcase
      return k;
   endfunction

   // result side
   always @(posedge clock) begin
      outcome_type o;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat: %h %0d", rsp_result_value,
                                           rsp_status);
         end else begin
            o = pending_rsp.pop_front();
            if (rsp_result_value !== o.value || rsp_status !== o.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp value %h status %0d, got value %h status %0d",
                           o.value, o.status, rsp_result_value, rsp_status);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else if (quiet) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 19);
   end

   initial begin
      row_type dir_rows[$];
      row_type r;
      int drain;
      int n;
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
         tbl_keys[i] = '0;
         tbl_values[i] = '0;
      end
      for (int i = 0; i < TOTAL_BUCKETS; i++) tbl_links[i] = 0;
      pool_used = 0;
      mask_bits = 4'd10;
      mismatches = 0;
      rsp_count = 0;
      stim_done = 0;
      hold_rsp = 0;
      quiet = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_GET;
      req_key = '0;
      req_value = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_bucket_count_log2 = 4'd10;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // op, key, value, typed, expected value, expected status
      dir_rows = '{
         '{OP_GET, 64'd5, 64'd0, 1, 64'd0, ST_MISS},
         '{OP_PUT, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'd0, ST_ZERO},
         '{OP_BAD, 64'd0, 64'd0, 1, 64'd0, ST_MISS},
         '{OP_BAD, 64'd7, 64'd9, 1, 64'd0, ST_MISS},
         '{OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'd0, ST_OK},
         '{OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1, 64'hFFFF_FFFF_FFFF_FFFF, ST_OK},
         '{OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 1, 64'd0, ST_MISS},
         '{OP_PUT, 64'd1, 64'hA5A5_5A5A_0F0F_F0F0, 0, 64'd0, ST_OK},
         '{OP_PUT, 64'h401, 64'd2, 0, 64'd0, ST_OK},
         '{OP_PUT, 64'h801, 64'd3, 0, 64'd0, ST_OK},
         '{OP_PUT, 64'hC01, 64'd4, 0, 64'd0, ST_OK},
         '{OP_GET, 64'hC01, 64'd0, 0, 64'd0, ST_OK},
         '{OP_REM, 64'h401, 64'd0, 0, 64'd0, ST_OK},
         '{OP_GET, 64'h401, 64'd0, 0, 64'd0, ST_OK},
         '{OP_PUT, 64'h1001, 64'd5, 0, 64'd0, ST_OK},
         '{OP_REM, 64'd0, 64'd0, 1, 64'd0, ST_ZERO},
         '{OP_GET, 64'd0, 64'd0, 1, 64'd0, ST_ZERO},
         '{OP_REM, 64'd1, 64'd0, 0, 64'd0, ST_OK},
         '{OP_REM, 64'd1, 64'd0, 1, 64'd0, ST_MISS}
      };
      foreach (dir_rows[i]) send_item(dir_rows[i]);

      // extremes of the mask, including wrap above the home bucket count
      set_mask(4'd0);
      for (int i = 0; i < 12; i++) begin
         r = '{OP_PUT, {$urandom, $urandom} | 64'd1, {$urandom, $urandom}, 0, '0, ST_OK};
         send_item(r);
      end
      set_mask(4'd15);
      for (int i = 0; i < 6; i++) begin
         r = '{OP_GET, rand_key(), '0, 0, '0, ST_OK};
         send_item(r);
      end

      // long receiver hold while the sender keeps offering
      fork
         begin
            hold_rsp = 1;
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end
         for (int i = 0; i < 30; i++) begin
            r = '{2'($urandom_range(2)), rand_key(), {$urandom, $urandom}, 0, '0, ST_OK};
            send_item(r);
         end
      join

      n = 0;
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: set_mask(4'd3);
            1: set_mask(4'd1);
            2: set_mask(4'd10);
            3: set_mask(4'd12);
            default: set_mask(4'd0);
         endcase
         quiet = (ph == 2);
         for (int i = 0; i < NUM_RANDOM / 5; i++) begin
            r.op = ($urandom_range(99) < 3) ? OP_BAD : 2'($urandom_range(2));
            r.key = ($urandom_range(99) < 3) ? 64'd0 : rand_key();
            r.value = {$urandom, $urandom};
            r.typed = 0;
            send_item(r);
            n++;
         end
      end
      quiet = 0;

      for (int i = 0; i < 4; i++) begin
         r = '{OP_PUT, {$urandom, $urandom} | 64'd1, 64'd0, 0, '0, ST_OK};
         send_item(r);
      end
      req_valid <= 1'b0;

      stim_done = 1;
      drain = 0;
      while (pending_rsp.size() != 0 && drain < 2000000) begin
         @(negedge clock);
         drain++;
      end
      repeat (600) @(negedge clock);
      if (pending_rsp.size() != 0 || mismatches != 0) $display("CHECK FAILED");
      else $display("CHECK OK");
      $finish;
   end

endmodule

@@ files.f @@
hdl/bht_pkg.sv
hdl/bht_front.sv
hdl/bht_queue.sv
hdl/bht_engine.sv
hdl/bucketed_hash_table_unit.sv
dv/bucketed_hash_table_unit_tb.sv
